>>> hw/rtl/ghalloc_pkg.sv
package ghalloc_pkg;

    // Table geometry.
    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int SLOT_PTR_W = $clog2(SLOT_COUNT + 1);
    localparam int GEN_W      = 8;
    localparam int LEVEL_SLOTS = 65536;
    localparam int LVL_W      = $clog2(LEVEL_SLOTS + 1);
    localparam int ADD_W      = LVL_W + 1;

    // Transaction field widths.
    localparam int KIND_W   = 2;
    localparam int IDX_W    = 10;
    localparam int VER_W    = 8;
    localparam int LVLCNT_W = 8;
    localparam int STATUS_W = 2;
    localparam int OFS_W    = 16;
    localparam int REF_W    = 16;

    localparam logic [REF_W-1:0] REFS_MAX = {REF_W{1'b1}};

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COPY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RELEASED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_STALE    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [IDX_W-1:0]    handle_index;
        logic [VER_W-1:0]    handle_version;
        logic [LVLCNT_W-1:0] level_count;
    } t_req;

    typedef struct packed {
        logic                  live;
        logic [REF_W-1:0]      refs;
        logic [GEN_W-1:0]      gen;
        logic [SLOT_PTR_W-1:0] next_free;
    } t_entry;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot_index;
        logic [VER_W-1:0]    slot_version;
        logic [OFS_W-1:0]    level_offset;
        logic [REF_W-1:0]    ref_count;
    } t_res;

    typedef struct packed {
        logic                  mem_we;
        logic [SLOT_W-1:0]     mem_addr;
        t_entry                mem_wdata;
        logic [SLOT_PTR_W-1:0] free_head;
        logic [SLOT_PTR_W-1:0] slots_used;
        logic [LVL_W-1:0]      next_offset;
        t_res                  res;
    } t_upd;

endpackage

>>> hw/rtl/ghalloc_req_if.sv
interface ghalloc_req_if;
    import ghalloc_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    handle_index;
    logic [VER_W-1:0]    handle_version;
    logic [LVLCNT_W-1:0] level_count;

    modport source (
        output valid, kind, handle_index, handle_version, level_count,
        input  ready
    );

    modport sink (
        input  valid, kind, handle_index, handle_version, level_count,
        output ready
    );
endinterface

>>> hw/rtl/ghalloc_res_if.sv
interface ghalloc_res_if;
    import ghalloc_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot_index;
    logic [VER_W-1:0]    slot_version;
    logic [OFS_W-1:0]    level_offset;
    logic [REF_W-1:0]    ref_count;

    modport source (
        output valid, status, slot_index, slot_version, level_offset, ref_count,
        input  ready
    );

    modport sink (
        input  valid, status, slot_index, slot_version, level_offset, ref_count,
        output ready
    );
endinterface

>>> hw/rtl/ghalloc_update.sv
module ghalloc_update (
    input  ghalloc_pkg::t_req                       i_req,
    input  ghalloc_pkg::t_entry                     i_entry,
    input  logic [ghalloc_pkg::SLOT_PTR_W-1:0]      i_free_head,
    input  logic [ghalloc_pkg::SLOT_PTR_W-1:0]      i_slots_used,
    input  logic [ghalloc_pkg::LVL_W-1:0]           i_next_offset,
    output ghalloc_pkg::t_upd                       o_upd
);
    import ghalloc_pkg::*;

    logic             is_create;
    logic             is_copy;
    logic             is_free;
    logic             from_free;
    logic             table_full;
    logic             offset_over;
    logic             hit;
    logic [ADD_W-1:0] add_a;
    logic [ADD_W-1:0] add_b;
    logic [ADD_W-1:0] add_sum;
    logic [REF_W-1:0] new_refs;
    logic [SLOT_W-1:0] new_slot;
    logic [GEN_W-1:0]  new_gen;
    logic [GEN_W-1:0]  bumped_gen;

    assign is_create = (i_req.kind == KIND_CREATE);
    assign is_copy   = (i_req.kind == KIND_COPY);
    assign is_free   = (i_req.kind == KIND_FREE);

    // One shared adder: offset plus level count for a create, count plus
    // one for a copy, count minus one for a free.
    always_comb begin
        if (is_create) begin
            add_a = ADD_W'(i_next_offset);
            add_b = ADD_W'(i_req.level_count);
        end else if (is_copy) begin
            add_a = ADD_W'(i_entry.refs);
            add_b = ADD_W'(1);
        end else begin
            add_a = ADD_W'(i_entry.refs);
            add_b = {ADD_W{1'b1}};
        end
    end

    assign add_sum = add_a + add_b;

    // Create checks: slot source and exhaustion of either resource.
    assign from_free   = (i_free_head < SLOT_PTR_W'(SLOT_COUNT));
    assign table_full  = !from_free && (i_slots_used >= SLOT_PTR_W'(SLOT_COUNT));
    assign offset_over = (add_sum > ADD_W'(LEVEL_SLOTS));

    // A handle is honored only for a written, live slot of matching generation.
    assign hit = (is_copy || is_free)
              && (SLOT_PTR_W'(i_req.handle_index) < i_slots_used)
              && i_entry.live
              && (VER_W'(i_entry.gen) == i_req.handle_version);

    assign new_slot   = from_free ? i_free_head[SLOT_W-1:0] : i_slots_used[SLOT_W-1:0];
    assign new_gen    = from_free ? i_entry.gen : '0;
    assign bumped_gen = i_entry.gen + GEN_W'(1);

    // Saturate on copy; plain decrement on free.
    assign new_refs = (is_copy && (i_entry.refs == REFS_MAX)) ? REFS_MAX
                                                               : add_sum[REF_W-1:0];

    // Write-back and result selection.
    always_comb begin
        o_upd              = '0;
        o_upd.free_head    = i_free_head;
        o_upd.slots_used   = i_slots_used;
        o_upd.next_offset  = i_next_offset;
        o_upd.mem_addr     = i_req.handle_index[SLOT_W-1:0];
        o_upd.mem_wdata    = i_entry;
        o_upd.res.status   = STATUS_STALE;
        o_upd.res.slot_index = i_req.handle_index;

        if (is_create) begin
            o_upd.res.slot_index = '0;
            if (table_full || offset_over) begin
                o_upd.res.status = STATUS_FULL;
            end else begin
                o_upd.mem_we              = 1'b1;
                o_upd.mem_addr            = new_slot;
                o_upd.mem_wdata.live      = 1'b1;
                o_upd.mem_wdata.refs      = REF_W'(1);
                o_upd.mem_wdata.gen       = new_gen;
                o_upd.mem_wdata.next_free = SLOT_PTR_W'(SLOT_COUNT);
                o_upd.next_offset         = add_sum[LVL_W-1:0];
                if (from_free) begin
                    o_upd.free_head = i_entry.next_free;
                end else begin
                    o_upd.slots_used = i_slots_used + SLOT_PTR_W'(1);
                end
                o_upd.res.status       = STATUS_DONE;
                o_upd.res.slot_index   = IDX_W'(new_slot);
                o_upd.res.slot_version = VER_W'(new_gen);
                o_upd.res.level_offset = i_next_offset[OFS_W-1:0];
                o_upd.res.ref_count    = REF_W'(1);
            end
        end else if (hit) begin
            o_upd.mem_we         = 1'b1;
            o_upd.mem_wdata.refs = new_refs;
            if (is_free && (new_refs == '0)) begin
                o_upd.mem_wdata.live      = 1'b0;
                o_upd.mem_wdata.gen       = bumped_gen;
                o_upd.mem_wdata.next_free = i_free_head;
                o_upd.free_head           = SLOT_PTR_W'(i_req.handle_index);
                o_upd.res.status          = STATUS_RELEASED;
                o_upd.res.slot_version    = VER_W'(bumped_gen);
            end else begin
                o_upd.res.status       = STATUS_DONE;
                o_upd.res.slot_version = VER_W'(i_entry.gen);
                o_upd.res.ref_count    = new_refs;
            end
        end
    end

endmodule

>>> hw/rtl/generational_handle_allocator_unit.sv
// Generational handle allocator. For each request transaction (create, copy
// or free), in the cycle it is accepted, the addressed slot entry is read from
// the single-port slot table memory; in the update state that follows, one
// shared adder computes the new count or detail-level offset, the entry is
// written back and the result is loaded into the output register. A new
// request is therefore accepted only once the previous one has been written
// back, and the update waits while a previous result is still held in the
// output register. Handles are checked against a slot fill count, so the table
// needs no clearing pass after reset and the block is ready once reset is released.
module generational_handle_allocator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ghalloc_req_if.sink   i_req,
    ghalloc_res_if.source o_res
);
    import ghalloc_pkg::*;

    t_state                r_state;
    t_state                n_state;
    t_req                  r_req;
    t_entry                r_entry;
    logic [SLOT_PTR_W-1:0] r_free_head;
    logic [SLOT_PTR_W-1:0] r_slots_used;
    logic [LVL_W-1:0]      r_next_offset;
    logic                  r_out_valid;
    t_res                  r_out;
    t_entry                mem [SLOT_COUNT];

    logic              accept;
    logic              commit;
    logic [SLOT_W-1:0] rd_addr;
    t_upd              upd;

    // Sequencer outputs.
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        commit      = (r_state == ST_UPDATE) && (!r_out_valid || o_res.ready);
    end

    assign accept = i_req.valid && i_req.ready;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (commit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A create looks at the free-list head; copy and free look at the handle.
    assign rd_addr = (i_req.kind == KIND_CREATE) ? r_free_head[SLOT_W-1:0]
                                                 : i_req.handle_index[SLOT_W-1:0];

    // Capture the request transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.kind           <= i_req.kind;
            r_req.handle_index   <= i_req.handle_index;
            r_req.handle_version <= i_req.handle_version;
            r_req.level_count    <= i_req.level_count;
        end
    end

    // Slot table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= mem[rd_addr];
        end
        if (commit && upd.mem_we) begin
            mem[upd.mem_addr] <= upd.mem_wdata;
        end
    end

    ghalloc_update u_update (
        .i_req         (r_req),
        .i_entry       (r_entry),
        .i_free_head   (r_free_head),
        .i_slots_used  (r_slots_used),
        .i_next_offset (r_next_offset),
        .o_upd         (upd)
    );

    // Allocator bookkeeping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head   <= SLOT_PTR_W'(SLOT_COUNT);
            r_slots_used  <= '0;
            r_next_offset <= '0;
        end else if (commit) begin
            r_free_head   <= upd.free_head;
            r_slots_used  <= upd.slots_used;
            r_next_offset <= upd.next_offset;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= upd.res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.slot_index   = r_out.slot_index;
    assign o_res.slot_version = r_out.slot_version;
    assign o_res.level_offset = r_out.level_offset;
    assign o_res.ref_count    = r_out.ref_count;

`ifndef SYNTH
    // The fill count never passes the table size.
    a_slots_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slots_used <= SLOT_PTR_W'(SLOT_COUNT))
        else $error("slot fill count exceeds table size");

    // The free-list head is empty or points at a slot that was written.
    a_free_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head == SLOT_PTR_W'(SLOT_COUNT)) || (r_free_head < r_slots_used))
        else $error("free-list head points past written slots");

    // The detail-level offset never passes the pool size.
    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_offset <= LVL_W'(LEVEL_SLOTS))
        else $error("detail-level offset exceeds pool size");

    // An accepted transaction always moves the sequencer to its update cycle.
    a_accept_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_UPDATE))
        else $error("accepted request did not enter update");

    // A new result appears only after an update cycle.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_UPDATE))
        else $error("result produced without an update cycle");
`endif

endmodule

>>> bench/generational_handle_allocator_unit_tb.sv
`timescale 1ns / 1ps

module generational_handle_allocator_unit_tb;
    import ghalloc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Two independent copies of the slot table: one steers stimulus, one checks.
    localparam int PLAN  = 0;
    localparam int CHECK = 1;

    localparam int LONG_HOLD   = 300;
    localparam int MAX_PRINTED = 200;

    typedef struct {
        t_req rq;
        int   gap;
    } backlog_item_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ghalloc_req_if req_bus ();
    ghalloc_res_if res_bus ();

    generational_handle_allocator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    // Shadow slot tables.
    logic [REF_W-1:0]      tbl_refs   [2][SLOT_COUNT];
    logic [GEN_W-1:0]      tbl_gen    [2][SLOT_COUNT];
    logic [SLOT_PTR_W-1:0] tbl_next   [2][SLOT_COUNT];
    logic                  tbl_live   [2][SLOT_COUNT];
    logic [SLOT_PTR_W-1:0] tbl_head   [2];
    logic [SLOT_PTR_W-1:0] tbl_used   [2];
    logic [LVL_W-1:0]      tbl_offset [2];

    backlog_item_t request_backlog[$];
    t_res          owed_answers[$];
    int            live_handles[$];

    int  mismatch_count = 0;
    int  answers_seen   = 0;
    int  tx_idle        = 0;
    int  rx_idle        = 0;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    bit  rx_quiet       = 1'b0;

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_table(input int m);
        for (int s = 0; s < SLOT_COUNT; s++) begin
            tbl_refs[m][s] = '0;
            tbl_gen[m][s]  = '0;
            tbl_next[m][s] = '0;
            tbl_live[m][s] = 1'b0;
        end
        tbl_head[m]   = SLOT_PTR_W'(SLOT_COUNT);
        tbl_used[m]   = '0;
        tbl_offset[m] = '0;
    endfunction

    // Applies one request to table copy m and returns the answer the block owes.
    function automatic t_res apply_handle_op(input int m, input t_req rq);
        t_res              ans;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] idx;
        logic [GEN_W-1:0]  gen;
        ans = '0;
        idx = rq.handle_index;
        if (rq.kind == KIND_CREATE) begin
            if (tbl_head[m] >= SLOT_COUNT && tbl_used[m] >= SLOT_COUNT) begin
                ans.status = STATUS_FULL;
            end else if (int'(tbl_offset[m]) + int'(rq.level_count) > LEVEL_SLOTS) begin
                ans.status = STATUS_FULL;
            end else begin
                // Reuse the free-list head first, else take a fresh slot.
                if (tbl_head[m] < SLOT_COUNT) begin
                    slot        = tbl_head[m][SLOT_W-1:0];
                    gen         = tbl_gen[m][slot];
                    tbl_head[m] = tbl_next[m][slot];
                end else begin
                    slot        = tbl_used[m][SLOT_W-1:0];
                    gen         = '0;
                    tbl_used[m] = tbl_used[m] + 1'b1;
                end
                ans.level_offset  = tbl_offset[m][OFS_W-1:0];
                tbl_offset[m]     = tbl_offset[m] + rq.level_count;
                tbl_refs[m][slot] = REF_W'(1);
                tbl_gen[m][slot]  = gen;
                tbl_next[m][slot] = SLOT_PTR_W'(SLOT_COUNT);
                tbl_live[m][slot] = 1'b1;
                ans.status        = STATUS_DONE;
                ans.slot_index    = slot;
                ans.slot_version  = gen;
                ans.ref_count     = REF_W'(1);
            end
        end else if (rq.kind == KIND_UNUSED || idx >= tbl_used[m] || !tbl_live[m][idx] ||
                     tbl_gen[m][idx] != rq.handle_version) begin
            ans.status     = STATUS_STALE;
            ans.slot_index = idx;
        end else if (rq.kind == KIND_COPY) begin
            if (tbl_refs[m][idx] != REFS_MAX) begin
                tbl_refs[m][idx] = tbl_refs[m][idx] + 1'b1;
            end
            ans.status       = STATUS_DONE;
            ans.slot_index   = idx;
            ans.slot_version = tbl_gen[m][idx];
            ans.ref_count    = tbl_refs[m][idx];
        end else begin
            tbl_refs[m][idx] = tbl_refs[m][idx] - 1'b1;
            ans.slot_index   = idx;
            if (tbl_refs[m][idx] != 0) begin
                ans.status       = STATUS_DONE;
                ans.slot_version = tbl_gen[m][idx];
                ans.ref_count    = tbl_refs[m][idx];
            end else begin
                // Last reference gone: retire the slot onto the free list.
                tbl_live[m][idx] = 1'b0;
                tbl_gen[m][idx]  = tbl_gen[m][idx] + 1'b1;
                tbl_next[m][idx] = tbl_head[m];
                tbl_head[m]      = {1'b0, idx};
                ans.status       = STATUS_RELEASED;
                ans.slot_version = tbl_gen[m][idx];
            end
        end
        return ans;
    endfunction

    function automatic t_req make_request(input logic [KIND_W-1:0] kind, input int idx,
                                          input int ver, input int levels);
        t_req rq;
        rq.kind           = kind;
        rq.handle_index   = IDX_W'(idx);
        rq.handle_version = VER_W'(ver);
        rq.level_count    = LVLCNT_W'(levels);
        return rq;
    endfunction

    // Queues a request for the driver and tracks which handles it leaves live.
    function automatic t_res queue_request(input t_req rq, input int gap);
        t_res          ans;
        backlog_item_t item;
        ans = apply_handle_op(PLAN, rq);
        if (rq.kind == KIND_CREATE && ans.status == STATUS_DONE) begin
            live_handles.push_back(int'(ans.slot_index));
        end
        if (ans.status == STATUS_RELEASED) begin
            for (int k = 0; k < live_handles.size(); k++) begin
                if (live_handles[k] == int'(ans.slot_index)) begin
                    live_handles.delete(k);
                    break;
                end
            end
        end
        item.rq  = rq;
        item.gap = gap;
        request_backlog.push_back(item);
        return ans;
    endfunction

    // Mostly valid handle traffic, with a share of damaged and unknown requests.
    function automatic t_req random_request();
        t_req rq;
        int   pick;
        int   slot;
        rq.kind           = KIND_CREATE;
        rq.handle_index   = IDX_W'($urandom);
        rq.handle_version = VER_W'($urandom);
        rq.level_count    = ($urandom_range(0, 3) == 0) ? LVLCNT_W'($urandom_range(0, 255))
                                                        : LVLCNT_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick >= 38 && live_handles.size() > 0) begin
            slot              = live_handles[$urandom_range(0, live_handles.size() - 1)];
            rq.handle_index   = IDX_W'(slot);
            rq.handle_version = tbl_gen[PLAN][slot];
            if (pick < 64) begin
                rq.kind = KIND_COPY;
            end else if (pick < 90) begin
                rq.kind = KIND_FREE;
            end else begin
                rq.kind = KIND_W'($urandom_range(1, 2));
                case ($urandom_range(0, 3))
                    0: rq.handle_version = tbl_gen[PLAN][slot] + VER_W'($urandom_range(1, 255));
                    1: rq.kind = KIND_UNUSED;
                    2: begin
                        rq.kind           = KIND_W'($urandom_range(1, 3));
                        rq.handle_index   = IDX_W'($urandom);
                        rq.handle_version = VER_W'($urandom);
                    end
                    default: begin
                        slot              = $urandom_range(0, int'(tbl_used[PLAN]) - 1);
                        rq.handle_index   = IDX_W'(slot);
                        rq.handle_version = tbl_gen[PLAN][slot];
                    end
                endcase
            end
        end
        return rq;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("answer %0d %s: got %0d, want %0d",
                                    answers_seen, name, got, want));
        end
    endtask

    // Waits until every queued request was taken and every answer came back.
    task automatic settle();
        while (request_backlog.size() != 0 || req_bus.valid || owed_answers.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Request driver: one transaction per item, then the item's idle gap.
    always @(posedge i_clk) begin
        t_req          arrived;
        backlog_item_t item;
        if (!i_rst_n) begin
            req_bus.valid          <= 1'b0;
            req_bus.kind           <= '0;
            req_bus.handle_index   <= '0;
            req_bus.handle_version <= '0;
            req_bus.level_count    <= '0;
            tx_idle = 0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                arrived.kind           = req_bus.kind;
                arrived.handle_index   = req_bus.handle_index;
                arrived.handle_version = req_bus.handle_version;
                arrived.level_count    = req_bus.level_count;
                owed_answers.push_back(apply_handle_op(CHECK, arrived));
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                    req_bus.valid <= 1'b0;
                end else if (request_backlog.size() > 0) begin
                    item = request_backlog.pop_front();
                    req_bus.valid          <= 1'b1;
                    req_bus.kind           <= item.rq.kind;
                    req_bus.handle_index   <= item.rq.handle_index;
                    req_bus.handle_version <= item.rq.handle_version;
                    req_bus.level_count    <= item.rq.level_count;
                    tx_idle = item.gap;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transaction, then stalls for a drawn count.
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            rx_idle = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                answers_seen++;
                if (owed_answers.size() == 0) begin
                    flag_mismatch($sformatf("answer %0d arrived with none owed (status %0d slot %0d)",
                                            answers_seen, res_bus.status, res_bus.slot_index));
                end else begin
                    want = owed_answers.pop_front();
                    check_field("status", 16'(res_bus.status), 16'(want.status));
                    check_field("slot_index", 16'(res_bus.slot_index), 16'(want.slot_index));
                    check_field("slot_version", 16'(res_bus.slot_version),
                                16'(want.slot_version));
                    check_field("level_offset", res_bus.level_offset, want.level_offset);
                    check_field("ref_count", res_bus.ref_count, want.ref_count);
                end
                rx_idle = rx_quiet ? 0 : $urandom_range(0, 19);
            end
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                rx_idle     = LONG_HOLD;
            end
            if (rx_idle > 0) begin
                rx_idle--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // Run limit.
    initial begin
        #(20_000_000);
        $display("FAILURE");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        t_res ans;
        int   count;
        int   slot;
        int   released;
        int   levels;

        i_rst_n                = 1'b0;
        req_bus.valid          = 1'b0;
        req_bus.kind           = '0;
        req_bus.handle_index   = '0;
        req_bus.handle_version = '0;
        req_bus.level_count    = '0;
        res_bus.ready          = 1'b0;
        clear_table(PLAN);
        clear_table(CHECK);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: level extremes, bad handles, release and reuse of slots.
        void'(queue_request(make_request(KIND_CREATE, 10'h3FF, 8'hFF, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_CREATE, 0, 0, 255), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_CREATE, 0, 0, 1), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_COPY, 0, 0, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_COPY, 0, 8'hFF, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_COPY, 1023, 0, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_FREE, 3, 0, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_UNUSED, 0, 0, 255), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_FREE, 0, 0, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_FREE, 0, 0, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_FREE, 0, 0, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_COPY, 0, 1, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_FREE, 1, 0, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_CREATE, 512, 8'h80, 2), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_CREATE, 0, 0, 3), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_CREATE, 0, 0, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_COPY, 1, 1, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_FREE, 512, 0, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_FREE, 1, 1, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_COPY, 2, 0, 0), $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_UNUSED, 1023, 8'hFF, 0), $urandom_range(0, 19)));
        settle();

        // Random traffic, with stretches without idle gaps, and one long
        // receiver hold while requests keep coming.
        count = 0;
        while (count < 280) begin
            void'(queue_request(random_request(),
                                (count % 150 < 30) ? 0 : $urandom_range(0, 19)));
            count++;
        end
        hold_requests++;
        settle();

        // Bulk phases run without idling on either side.
        rx_quiet = 1'b1;

        // Create and release one slot repeatedly until its generation wraps.
        // The creates also draw down most of the detail-level range.
        for (int n = 0; n < 256; n++) begin
            levels = LEVEL_SLOTS - int'(tbl_offset[PLAN]);
            if (levels > 255) begin
                levels = 255;
            end
            ans = queue_request(make_request(KIND_CREATE, $urandom, $urandom, levels), 0);
            void'(queue_request(make_request(KIND_FREE, ans.slot_index, ans.slot_version,
                                             $urandom), 0));
        end
        settle();
        rx_quiet = 1'b0;

        // Use up the detail-level range, then fill it exactly to the end.
        do begin
            ans = queue_request(make_request(KIND_CREATE, $urandom, $urandom, 255),
                                $urandom_range(0, 19));
        end while (ans.status == STATUS_DONE);
        if (int'(tbl_offset[PLAN]) < LEVEL_SLOTS) begin
            void'(queue_request(make_request(KIND_CREATE, $urandom, $urandom,
                                             LEVEL_SLOTS - int'(tbl_offset[PLAN])),
                                $urandom_range(0, 19)));
        end
        void'(queue_request(make_request(KIND_CREATE, $urandom, $urandom, 1),
                            $urandom_range(0, 19)));
        void'(queue_request(make_request(KIND_CREATE, $urandom, $urandom, 0),
                            $urandom_range(0, 19)));

        // Release a few lightly used slots and take them back off the free list.
        released = 0;
        while (released < 4) begin
            slot = live_handles[$urandom_range(0, live_handles.size() - 1)];
            if (tbl_refs[PLAN][slot] < 64) begin
                do begin
                    ans = queue_request(make_request(KIND_FREE, slot, tbl_gen[PLAN][slot],
                                                     $urandom), $urandom_range(0, 19));
                end while (ans.status == STATUS_DONE);
                released++;
            end
        end
        repeat (5) begin
            void'(queue_request(make_request(KIND_CREATE, $urandom, $urandom, 0),
                                $urandom_range(0, 19)));
        end
        repeat (60) begin
            void'(queue_request(random_request(), $urandom_range(0, 19)));
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && owed_answers.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
